### design/punctured_convolutional_encoder_core_macros.svh
// Assertion macros used by the punctured convolutional encoder core.
`ifndef PUNCTURED_CONVOLUTIONAL_ENCODER_CORE_MACROS_SVH
`define PUNCTURED_CONVOLUTIONAL_ENCODER_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define PCE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pce assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define PCE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pce assertion failed");
`else
`define PCE_ASSERT_NOW(label, ante, cons)
`define PCE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/pce_pkg.sv
// Types, constants and helper functions of the punctured convolutional encoder.
`timescale 1ns / 1ps
package pce_pkg;

   localparam int MaxInputs   = 4;
   localparam int MaxOutputs  = 4;
   localparam int MaxMemory   = 7;
   localparam int PunctureMax = 32;
   localparam int MemLenWidth = 3;

   typedef enum logic [2:0] {
      REG_INPUT_COUNT     = 3'd0,
      REG_OUTPUT_COUNT    = 3'd1,
      REG_MEMORY_LENGTHS  = 3'd2,
      REG_GENERATORS_LOW  = 3'd3,
      REG_GENERATORS_HIGH = 3'd4,
      REG_PUNCTURE_PATTERN = 3'd5,
      REG_PUNCTURE_LENGTH = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [3:0] message_group;
      logic       last_group;
   } req_type;

   typedef struct packed {
      logic [3:0] kept_bits;
      logic [2:0] kept_count;
      logic       end_of_block;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  input_count;
      logic [2:0]  output_count;
      logic [11:0] memory_lengths;
      logic [63:0] generators_low;
      logic [63:0] generators_high;
      logic [31:0] puncture_pattern;
      logic [5:0]  puncture_length;
   } cfg_type;

   typedef logic [MaxInputs-1:0][MaxMemory-1:0] mem_type;

   // Result of encoding and puncturing one group, plus the state it leaves.
   typedef struct packed {
      logic [3:0] kept_bits;
      logic [2:0] kept_count;
      mem_type    mem_next;
      logic [4:0] pos_next;
   } enc_type;

   // Zero counts act as one; counts above the maximum saturate.
   function automatic logic [2:0] clamp_count(input logic [2:0] value,
                                              input logic [2:0] limit);
      logic [2:0] res;
      if (value == 3'd0) begin
         res = 3'd1;
      end else if (value > limit) begin
         res = limit;
      end else begin
         res = value;
      end
      return res;
   endfunction

   function automatic logic [2:0] row_mem_len(input cfg_type cfg, input logic [1:0] row);
      return cfg.memory_lengths[MemLenWidth*row +: MemLenWidth];
   endfunction

endpackage

### design/pce_group_enc.sv
// Encodes one message group and punctures the coded bits of that group.
`timescale 1ns / 1ps
module pce_group_enc (
   input  pce_pkg::cfg_type cfg,
   input  pce_pkg::mem_type mem_bits,
   input  logic [4:0]       pos,
   input  logic [3:0]       msg,
   output pce_pkg::enc_type enc
);
   import pce_pkg::*;

   logic [2:0] k;
   logic [2:0] n;
   logic [5:0] len;

   always_comb begin
      k   = clamp_count(cfg.input_count, 3'(MaxInputs));
      n   = clamp_count(cfg.output_count, 3'(MaxOutputs));
      len = 6'd1;
      if (cfg.puncture_length == 6'd0) begin
         len = 6'd1;
      end else if (cfg.puncture_length > 6'(PunctureMax)) begin
         len = 6'(PunctureMax);
      end else begin
         len = cfg.puncture_length;
      end
   end

   // Row k-1 occupies the lowest segment of each column generator.
   logic [5:0]       off [MaxInputs];
   logic [2:0]       ml [MaxInputs];
   logic [MaxInputs-1:0] act;
   logic [MaxMemory:0]   data [MaxInputs];
   logic [5:0]       acc;
   logic [1:0]       sel;

   always_comb begin
      acc = 6'd0;
      sel = 2'd0;
      for (int r = MaxInputs - 1; r >= 0; r--) begin
         ml[r]  = row_mem_len(cfg, 2'(r));
         act[r] = (3'(r) < k);
         off[r] = acc;
         if (act[r]) begin
            acc = acc + 6'(ml[r]) + 6'd1;
         end
      end
      for (int r = 0; r < MaxInputs; r++) begin
         sel     = 2'(k - 3'(r) - 3'd1);
         data[r] = {mem_bits[r], act[r] & msg[sel]};
      end
   end

   logic [31:0] gen [MaxOutputs];
   logic [3:0]  coded;
   logic [5:0]  idx;

   assign gen[0] = cfg.generators_low[31:0];
   assign gen[1] = cfg.generators_low[63:32];
   assign gen[2] = cfg.generators_high[31:0];
   assign gen[3] = cfg.generators_high[63:32];

   // Parity of each column generator over the taps of all active rows.
   always_comb begin
      idx = 6'd0;
      for (int c = 0; c < MaxOutputs; c++) begin
         coded[c] = 1'b0;
         for (int r = 0; r < MaxInputs; r++) begin
            for (int d = 0; d <= MaxMemory; d++) begin
               idx = off[r] + 6'(d);
               if (act[r] && (3'(d) <= ml[r]) && (idx < 6'd32)) begin
                  coded[c] = coded[c] ^ (gen[c][idx[4:0]] & data[r][d]);
               end
            end
         end
      end
   end

   logic [4:0] p;
   logic [5:0] p_inc;
   logic [2:0] cnt;
   logic [3:0] bits;

   // Walk the cyclic keep mask once per coded bit, column 0 first.
   always_comb begin
      p     = pos;
      p_inc = 6'd0;
      cnt   = 3'd0;
      bits  = 4'd0;
      if ({1'b0, p} >= len) begin
         p = 5'd0;
      end
      for (int c = 0; c < MaxOutputs; c++) begin
         if (3'(c) < n) begin
            if (cfg.puncture_pattern[p]) begin
               bits[cnt[1:0]] = coded[c];
               cnt            = cnt + 3'd1;
            end
            p_inc = {1'b0, p} + 6'd1;
            if (p_inc >= len) begin
               p = 5'd0;
            end else begin
               p = p_inc[4:0];
            end
         end
      end
   end

   always_comb begin
      enc.kept_bits  = bits;
      enc.kept_count = cnt;
      enc.pos_next   = p;
      for (int r = 0; r < MaxInputs; r++) begin
         if (act[r]) begin
            enc.mem_next[r] = data[r][MaxMemory-1:0] &
                              MaxMemory'((8'd1 << ml[r]) - 8'd1);
         end else begin
            enc.mem_next[r] = mem_bits[r];
         end
      end
   end

endmodule

### design/punctured_convolutional_encoder_core.sv
// Top level of the punctured convolutional encoder: registers, tail and output skid.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_payload (message_group, last_group)
//   rsp      out        rsp_valid/rsp_ready   rsp_payload (kept_bits, kept_count, eob)
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// While req_ready is high one group is encoded per cycle, in the cycle it is accepted.
// A last group is followed by one tail result per cycle while the skid entry is empty,
// as many as the longest active memory length; no request is accepted while the tail runs.
// A two-entry output (result register plus skid register) keeps req_ready
// independent of rsp_ready; req_ready drops while the skid entry is full or a tail runs.
// Reset is synchronous, restores the default configuration and clears memory and position.
`timescale 1ns / 1ps
module punctured_convolutional_encoder_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pce_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pce_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_data
);
   import pce_pkg::*;

`include "punctured_convolutional_encoder_core_macros.svh"

   cfg_type    cfg_ff, cfg_in;
   mem_type    mem_ff, mem_in;
   logic [4:0] pos_ff, pos_in;
   logic [2:0] tail_ff, tail_in;
   rsp_type    out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    skid_ff, skid_in;
   logic       skid_valid_ff, skid_valid_in;

   logic       req_fire;
   logic       tail_step;
   logic       produce;
   logic [3:0] enc_msg;
   enc_type    enc;
   rsp_type    new_rsp;
   logic [2:0] k;
   logic [2:0] tail_len;
   logic [2:0] ml;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_INPUT_COUNT:      cfg_in.input_count      = csr_data[2:0];
            REG_OUTPUT_COUNT:     cfg_in.output_count     = csr_data[2:0];
            REG_MEMORY_LENGTHS:   cfg_in.memory_lengths   = csr_data[11:0];
            REG_GENERATORS_LOW:   cfg_in.generators_low   = csr_data;
            REG_GENERATORS_HIGH:  cfg_in.generators_high  = csr_data;
            REG_PUNCTURE_PATTERN: cfg_in.puncture_pattern = csr_data[31:0];
            REG_PUNCTURE_LENGTH:  cfg_in.puncture_length  = csr_data[5:0];
            default: ;
         endcase
      end
   end

   assign req_ready = !skid_valid_ff && (tail_ff == 3'd0);
   assign req_fire  = req_valid && req_ready;
   assign tail_step = (tail_ff != 3'd0) && !skid_valid_ff;
   assign produce   = req_fire || tail_step;
   assign enc_msg   = tail_step ? 4'd0 : req_payload.message_group;

   // Tail length is the longest memory among the active inputs.
   always_comb begin
      k        = clamp_count(cfg_ff.input_count, 3'(MaxInputs));
      tail_len = 3'd0;
      ml       = 3'd0;
      for (int r = 0; r < MaxInputs; r++) begin
         ml = row_mem_len(cfg_ff, 2'(r));
         if ((3'(r) < k) && (ml > tail_len)) begin
            tail_len = ml;
         end
      end
   end

   pce_group_enc u_group_enc (
      .cfg      (cfg_ff),
      .mem_bits (mem_ff),
      .pos      (pos_ff),
      .msg      (enc_msg),
      .enc      (enc)
   );

   always_comb begin
      new_rsp.kept_bits  = enc.kept_bits;
      new_rsp.kept_count = enc.kept_count;
      if (tail_step) begin
         new_rsp.end_of_block = (tail_ff == 3'd1);
      end else begin
         new_rsp.end_of_block = req_payload.last_group && (tail_len == 3'd0);
      end
   end

   // Encoder state: the block end clears memory and puncture position.
   always_comb begin
      mem_in  = mem_ff;
      pos_in  = pos_ff;
      tail_in = tail_ff;
      if (produce) begin
         if (new_rsp.end_of_block) begin
            mem_in = '0;
            pos_in = 5'd0;
         end else begin
            mem_in = enc.mem_next;
            pos_in = enc.pos_next;
         end
         if (tail_step) begin
            tail_in = tail_ff - 3'd1;
         end else if (req_payload.last_group) begin
            tail_in = tail_len;
         end
      end
   end

   // The skid entry catches a new result while the output register is stalled.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (produce) begin
         if (!out_valid_ff || rsp_ready) begin
            out_in       = new_rsp;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = new_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_count      <= 3'd1;
         cfg_ff.output_count     <= 3'd2;
         cfg_ff.memory_lengths   <= 12'd6;
         cfg_ff.generators_low   <= 64'd0;
         cfg_ff.generators_high  <= 64'd0;
         cfg_ff.puncture_pattern <= 32'd1;
         cfg_ff.puncture_length  <= 6'd1;
         mem_ff                  <= '0;
         pos_ff                  <= 5'd0;
         tail_ff                 <= 3'd0;
         out_valid_ff            <= 1'b0;
         skid_valid_ff           <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         mem_ff        <= mem_in;
         pos_ff        <= pos_in;
         tail_ff       <= tail_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   `PCE_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   `PCE_ASSERT_NOW(a_kept_bits_clean, rsp_valid, (rsp_payload.kept_bits >> rsp_payload.kept_count) == 4'd0)
   `PCE_ASSERT_NEXT(a_tail_countdown, tail_step, tail_ff == $past(tail_ff) - 3'd1)
   `PCE_ASSERT_NOW(a_no_accept_in_tail, tail_ff != 3'd0, !req_fire)

endmodule

### tb/punctured_convolutional_encoder_core_tb.sv
// Self-checking testbench for the punctured convolutional encoder core.
`timescale 1ns / 1ps
module punctured_convolutional_encoder_core_tb;
   import pce_pkg::*;

   localparam int RandomItems  = 270;
   localparam int DrainLimit   = 20000;
   localparam int SettleCycles = 16;
   localparam int ReportLimit  = 100;
   localparam int TimeoutNs    = 3000000;

   typedef enum int {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_payload = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_payload;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = REG_INPUT_COUNT;
   logic [63:0]   csr_data = '0;

   // Local copy of the block: registers, shift registers, puncture position.
   cfg_type cfg_model = '{3'd1, 3'd2, 12'd6, 64'd0, 64'd0, 32'd1, 6'd1};
   mem_type shift_regs = '0;
   int      punct_pos = 0;

   req_type pending_groups[$];
   rsp_type expected_results[$];
   int      error_count = 0;

   int             burst_left = 8;
   int             gap_left = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left = 0;
   int             stall_tick = 0;

   punctured_convolutional_encoder_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int bounded_count(int value, int limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   function automatic int tap_span(int row);
      return int'(cfg_model.memory_lengths[3*row +: 3]);
   endfunction

   // Coded bits of one group, column c at bit c; shifts the group into memory.
   function automatic logic [3:0] encode_group(logic [3:0] msg, int k, int n);
      logic [3:0]  coded;
      logic [31:0] gen;
      logic [7:0]  taps;
      logic        acc;
      int          off;
      int          w;
      coded = '0;
      for (int c = 0; c < n; c++) begin
         case (c)
            0: gen = cfg_model.generators_low[31:0];
            1: gen = cfg_model.generators_low[63:32];
            2: gen = cfg_model.generators_high[31:0];
            default: gen = cfg_model.generators_high[63:32];
         endcase
         off = 0;
         acc = 1'b0;
         // The last row takes the lowest segment of the generator word.
         for (int r = k - 1; r >= 0; r--) begin
            w = tap_span(r) + 1;
            taps = (off < 32) ? 8'((gen >> off) & ((32'd1 << w) - 32'd1)) : 8'd0;
            acc ^= ^(taps & {shift_regs[r], msg[k-1-r]});
            off += w;
         end
         coded[c] = acc;
      end
      for (int r = 0; r < k; r++) begin
         shift_regs[r] = 7'({shift_regs[r], msg[k-1-r]} & ((8'd1 << tap_span(r)) - 8'd1));
      end
      return coded;
   endfunction

   function automatic rsp_type puncture_group(logic [3:0] coded, int n, logic eob);
      rsp_type res;
      int      len;
      int      cnt;
      len = bounded_count(int'(cfg_model.puncture_length), PunctureMax);
      if (punct_pos >= len) punct_pos = 0;
      res = '0;
      cnt = 0;
      for (int c = 0; c < n; c++) begin
         if (cfg_model.puncture_pattern[punct_pos]) begin
            res.kept_bits[cnt] = coded[c];
            cnt++;
         end
         punct_pos++;
         if (punct_pos >= len) punct_pos = 0;
      end
      res.kept_count = 3'(cnt);
      res.end_of_block = eob;
      return res;
   endfunction

   function automatic void predict_group(req_type item);
      int k;
      int n;
      int tail;
      k = bounded_count(int'(cfg_model.input_count), MaxInputs);
      n = bounded_count(int'(cfg_model.output_count), MaxOutputs);
      tail = 0;
      if (item.last_group) begin
         for (int r = 0; r < k; r++) begin
            if (tap_span(r) > tail) tail = tap_span(r);
         end
      end
      expected_results.insert(expected_results.size(),
                              puncture_group(encode_group(item.message_group, k, n), n,
                                             item.last_group && tail == 0));
      if (item.last_group) begin
         for (int t = 0; t < tail; t++) begin
            expected_results.insert(expected_results.size(),
                                    puncture_group(encode_group(4'd0, k, n), n,
                                                   t + 1 == tail));
         end
         shift_regs = '0;
         punct_pos = 0;
      end
   endfunction

   function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= ReportLimit)
            $error("%s: expected %0h, actual %0h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : driver
      logic    next_valid;
      req_type next_payload;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_payload = req_payload;
         if (req_valid && req_ready) begin
            predict_group(req_payload);
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_groups.size() != 0) begin
               next_payload = pending_groups[0];
               pending_groups.delete(0);
               next_valid = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         req_valid <= next_valid;
         req_payload <= next_payload;
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      logic    next_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= ReportLimit)
                  $error("result with nothing expected: %p", rsp_payload);
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               check_field("kept_bits", want.kept_bits, rsp_payload.kept_bits);
               check_field("kept_count", want.kept_count, rsp_payload.kept_count);
               check_field("end_of_block", want.end_of_block, rsp_payload.end_of_block);
            end
         end
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            READY_ALWAYS: next_ready = 1'b1;
            READY_HALF: next_ready = $urandom_range(0, 1);
            READY_SPARSE: next_ready = ($urandom_range(0, 3) == 0);
            default: begin
               next_ready = (stall_tick % 8) < 5;
               stall_tick++;
            end
         endcase
         rsp_ready <= next_ready;
      end
   end

   function automatic void queue_group(logic [3:0] msg, logic last);
      req_type item;
      item.message_group = msg;
      item.last_group = last;
      pending_groups.insert(pending_groups.size(), item);
   endfunction

   task automatic write_register(csr_index_type index, logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         REG_INPUT_COUNT: cfg_model.input_count = value[2:0];
         REG_OUTPUT_COUNT: cfg_model.output_count = value[2:0];
         REG_MEMORY_LENGTHS: cfg_model.memory_lengths = value[11:0];
         REG_GENERATORS_LOW: cfg_model.generators_low = value;
         REG_GENERATORS_HIGH: cfg_model.generators_high = value;
         REG_PUNCTURE_PATTERN: cfg_model.puncture_pattern = value[31:0];
         REG_PUNCTURE_LENGTH: cfg_model.puncture_length = value[5:0];
         default: ;
      endcase
   endtask

   // Unused upper data bits carry noise; the block must ignore them.
   task automatic apply_settings(cfg_type s);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      write_register(REG_INPUT_COUNT, {junk[63:3], s.input_count});
      write_register(REG_OUTPUT_COUNT, {junk[63:3], s.output_count});
      write_register(REG_MEMORY_LENGTHS, {junk[63:12], s.memory_lengths});
      write_register(REG_GENERATORS_LOW, s.generators_low);
      write_register(REG_GENERATORS_HIGH, s.generators_high);
      write_register(REG_PUNCTURE_PATTERN, {junk[63:32], s.puncture_pattern});
      write_register(REG_PUNCTURE_LENGTH, {junk[63:6], s.puncture_length});
   endtask

   task automatic wait_for_idle();
      int waited;
      waited = 0;
      while ((pending_groups.size() != 0 || req_valid || expected_results.size() != 0)
             && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      if (waited >= DrainLimit) begin
         error_count++;
         $error("results still missing: %0d", expected_results.size());
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   initial begin : stimulus
      cfg_type settings;
      int      random_count;
      int      phase_len;
      int      block_left;
      int      pick;
      logic    last;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: one input, memory six, all generators zero.
      queue_group(4'hF, 1'b0);
      queue_group(4'hA, 1'b1);
      wait_for_idle();

      // Widest code with full memory gives the longest tail.
      settings = '{3'd4, 3'd4, 12'hFFF, '1, '1, '1, 6'd32};
      apply_settings(settings);
      queue_group(4'hF, 1'b0);
      queue_group(4'h0, 1'b0);
      queue_group(4'h5, 1'b0);
      queue_group(4'hA, 1'b1);
      wait_for_idle();

      // Zero input count, output count above the maximum, no memory so no tail, and a pattern that drops everything.
      settings = '{3'd0, 3'd7, 12'h000, {$urandom, $urandom}, {$urandom, $urandom},
                   32'hFFFF_FFFE, 6'd0};
      apply_settings(settings);
      queue_group(4'hF, 1'b1);
      queue_group(4'h3, 1'b0);
      queue_group(4'hC, 1'b1);
      wait_for_idle();

      // Saturated input count and puncture length, mixed memory lengths.
      settings = '{3'd5, 3'd0, 12'b111_000_101_010, {$urandom, $urandom},
                   {$urandom, $urandom}, $urandom, 6'd63};
      apply_settings(settings);
      queue_group(4'h9, 1'b0);
      queue_group(4'h6, 1'b0);
      queue_group(4'hF, 1'b0);
      queue_group(4'h1, 1'b1);
      wait_for_idle();

      // Leave the puncture position at four, then shorten the pattern below it.
      settings = '{3'd2, 3'd3, 12'h00B, {$urandom, $urandom}, {$urandom, $urandom},
                   32'h0000_0015, 6'd5};
      apply_settings(settings);
      queue_group(4'h3, 1'b0);
      queue_group(4'h2, 1'b0);
      queue_group(4'h1, 1'b0);
      wait_for_idle();
      settings.puncture_length = 6'd3;
      apply_settings(settings);
      queue_group(4'h2, 1'b0);
      queue_group(4'h3, 1'b0);
      queue_group(4'h1, 1'b1);
      wait_for_idle();

      random_count = 0;
      block_left = 0;
      while (random_count < RandomItems) begin
         settings.input_count = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                           : 3'($urandom_range(1, 4));
         settings.output_count = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                            : 3'($urandom_range(1, 4));
         pick = $urandom_range(0, 5);
         settings.memory_lengths = (pick == 0) ? 12'h000 : (pick == 1) ? 12'hFFF
                                                         : 12'($urandom);
         pick = $urandom_range(0, 7);
         settings.generators_low = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
         pick = $urandom_range(0, 7);
         settings.generators_high = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
         pick = $urandom_range(0, 7);
         settings.puncture_pattern = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
         case ($urandom_range(0, 7))
            0: settings.puncture_length = 6'd0;
            1: settings.puncture_length = 6'd1;
            2: settings.puncture_length = 6'd32;
            3: settings.puncture_length = 6'd63;
            default: settings.puncture_length = 6'($urandom_range(1, 32));
         endcase
         apply_settings(settings);

         // Mostly complete blocks; a stray last now and then, and a block may
         // run on across a change of settings.
         phase_len = $urandom_range(8, 32);
         for (int i = 0; i < phase_len; i++) begin
            if (block_left == 0)
               block_left = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 10);
            block_left--;
            last = (block_left == 0) || ($urandom_range(0, 15) == 0);
            if (last) block_left = 0;
            queue_group(4'($urandom), last);
         end
         random_count += phase_len;
         wait_for_idle();
      end

      wait_for_idle();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #(TimeoutNs);
      $display("simulation failed");
      $finish;
   end

endmodule
